FILE: rtl/xz_index_field_checker_defines.svh
// ----------------------------------------------------------------------------
// xz_index_field_checker_defines
// Assertion macros used by the port-level checker of the xz index field checker.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef XZ_INDEX_FIELD_CHECKER_DEFINES_SVH
`define XZ_INDEX_FIELD_CHECKER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define XZIC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define XZIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/xzic_pkg.sv
// ----------------------------------------------------------------------------
// xzic_pkg
// Types, constants and the CRC-32 byte update for the xz index field checker.
// ----------------------------------------------------------------------------
`default_nettype none

package xzic_pkg;

  // Default limit on the length of one variable-length integer, in bytes.
  localparam int unsigned MaxVarintBytes = 9;

  // Width of the saturating byte counter of the index field.
  localparam int unsigned TotalW = 35;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // Result status codes, in the order the result field defines them.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SIZE         = 3'd1,
    ST_CRC          = 3'd2,
    ST_INDICATOR    = 3'd3,
    ST_COUNT        = 3'd4,
    ST_UNPADDED     = 3'd5,
    ST_UNCOMPRESSED = 3'd6,
    ST_PADDING      = 3'd7
  } status_e;

  // Parser phase: which field the next body byte belongs to.
  typedef enum logic [2:0] {
    PH_INDICATOR = 3'd0,
    PH_COUNT     = 3'd1,
    PH_UNPADDED  = 3'd2,
    PH_UNCOMP    = 3'd3,
    PH_PADDING   = 3'd4,
    PH_HALT      = 3'd5
  } phase_e;

  // One byte through the reflected CRC-32 register.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/xzic_if.sv
// ----------------------------------------------------------------------------
// xzic_byte_if / xzic_res_if
// Valid/ready channels of the xz index field checker: index bytes in,
// one check result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface xzic_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] index_byte;
  logic       last;

  modport source (output valid, output index_byte, output last, input ready);
  modport sink (input valid, input index_byte, input last, output ready);
endinterface

interface xzic_res_if;
  logic                  valid;
  logic                  ready;
  logic [63:0]           block_bytes;
  logic [63:0]           uncompressed_bytes;
  logic [2:0]            status;

  modport source (output valid, output block_bytes, output uncompressed_bytes,
                  output status, input ready);
  modport sink (input valid, input block_bytes, input uncompressed_bytes,
                input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/xz_index_field_checker.sv
// ----------------------------------------------------------------------------
// xz_index_field_checker
// Checks one xz index field delivered byte by byte and reports its sums.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one index byte per beat, with last set on the final byte of
//   the field. out_o carries one result beat per field: the rounded sum of
//   the unpadded sizes, the sum of the uncompressed sizes and a status code.
//   The sums read zero whenever the status is not OK.
// Dataflow and throughput:
//   A byte beat is taken into an input register, and from there the bytewise
//   CRC update, the varint accumulate and the sum updates run in one pass
//   into the state registers. The result register is loaded in that same
//   pass, and the result beat is offered on out_o from that register.
//   One byte is taken every cycle, except that a last byte holds while a
//   result waits untaken; the CRC byte update and the 64-bit sum adds set
//   the length of that single pass.
// Reset and stalls:
//   Reset clears all parser state and drops both valids. After each result
//   the block clears itself and the next byte starts a new field. While a
//   result waits on out_o, bytes keep flowing in; only a further last byte
//   holds in the input register until the waiting result has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module xz_index_field_checker #(
  parameter int unsigned MAX_VARINT_BYTES = xzic_pkg::MaxVarintBytes
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  xzic_byte_if.sink   in_i,
  xzic_res_if.source  out_o
);

  // Varint byte position counter, wide enough to hold the limit itself.
  localparam int unsigned PosW = $clog2(MAX_VARINT_BYTES + 1);
  localparam logic [xzic_pkg::TotalW-1:0] TotalMax = '1;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Result register.
  logic                  out_valid_q;
  logic [63:0]           out_block_q;
  logic [63:0]           out_uncomp_q;
  xzic_pkg::status_e     out_status_q;

  // Checker state.
  logic [7:0]                tail_q [4];
  logic [7:0]                tail_d [4];
  logic [2:0]                fill_q, fill_d;
  logic [xzic_pkg::TotalW-1:0] total_q, total_d;
  logic [31:0]               crc_q, crc_d;
  xzic_pkg::phase_e          phase_q, phase_d;
  logic [62:0]               vval_q, vval_d;
  logic [PosW-1:0]           vpos_q, vpos_d;
  logic [62:0]               rec_q, rec_d;
  logic [63:0]               bsum_q, bsum_d;
  logic [63:0]               usum_q, usum_d;
  logic [2:0]                pad_q, pad_d;
  xzic_pkg::status_e         ferr_q, ferr_d;

  logic              advance;
  logic              pop;
  logic [7:0]        old_byte;
  logic [62:0]       vnew;
  logic              v_err;
  logic              v_done;
  logic [31:0]       tail_word;
  xzic_pkg::status_e status;

  // The stage moves on unless a last byte would overwrite an untaken result.
  assign advance    = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.index_byte;
      in_last_q <= in_i.last;
    end
  end

  // A byte reaches the CRC and the parser only when a newer byte pushes it
  // out of the four-byte tail, so the trailing CRC word is never parsed.
  assign pop      = (fill_q == 3'd4);
  assign old_byte = tail_q[0];

  // Varint step on the byte leaving the tail.
  always_comb begin
    vnew   = vval_q | (63'(old_byte[6:0]) << (6'(vpos_q) * 6'd7));
    v_err  = 1'b0;
    v_done = 1'b0;
    if (vpos_q >= PosW'(MAX_VARINT_BYTES)) begin
      v_err = 1'b1;
    end else if (vpos_q != '0 && old_byte == 8'h00) begin
      v_err = 1'b1;
    end else if (old_byte[7]) begin
      v_err = (vpos_q >= PosW'(MAX_VARINT_BYTES - 1));
    end else begin
      v_done = 1'b1;
    end
  end

  always_comb begin
    tail_d = tail_q;
    fill_d = fill_q;
    total_d = total_q;
    crc_d = crc_q;
    phase_d = phase_q;
    vval_d = vval_q;
    vpos_d = vpos_q;
    rec_d = rec_q;
    bsum_d = bsum_q;
    usum_d = usum_q;
    pad_d = pad_q;
    ferr_d = ferr_q;

    if (advance) begin
      if (pop) begin
        tail_d[0] = tail_q[1];
        tail_d[1] = tail_q[2];
        tail_d[2] = tail_q[3];
        tail_d[3] = in_byte_q;
        crc_d = xzic_pkg::crc32_byte(crc_q, old_byte);

        unique case (phase_q)
          xzic_pkg::PH_INDICATOR: begin
            if (old_byte != 8'h00) begin
              ferr_d  = xzic_pkg::ST_INDICATOR;
              phase_d = xzic_pkg::PH_HALT;
            end else begin
              phase_d = xzic_pkg::PH_COUNT;
            end
          end
          xzic_pkg::PH_COUNT, xzic_pkg::PH_UNPADDED, xzic_pkg::PH_UNCOMP: begin
            if (v_err) begin
              phase_d = xzic_pkg::PH_HALT;
              case (phase_q)
                xzic_pkg::PH_COUNT:    ferr_d = xzic_pkg::ST_COUNT;
                xzic_pkg::PH_UNPADDED: ferr_d = xzic_pkg::ST_UNPADDED;
                default:               ferr_d = xzic_pkg::ST_UNCOMPRESSED;
              endcase
            end else if (!v_done) begin
              vval_d = vnew;
              vpos_d = vpos_q + PosW'(1);
            end else begin
              vval_d = '0;
              vpos_d = '0;
              case (phase_q)
                xzic_pkg::PH_COUNT: begin
                  rec_d   = vnew;
                  phase_d = (vnew == '0) ? xzic_pkg::PH_PADDING : xzic_pkg::PH_UNPADDED;
                end
                xzic_pkg::PH_UNPADDED: begin
                  // Unpadded size rounded up to a multiple of four; zero stays zero.
                  bsum_d  = bsum_q + ((64'(vnew) + 64'd3) & ~64'h3);
                  phase_d = xzic_pkg::PH_UNCOMP;
                end
                default: begin
                  usum_d  = usum_q + 64'(vnew);
                  rec_d   = rec_q - 63'd1;
                  phase_d = (rec_q == 63'd1) ? xzic_pkg::PH_PADDING : xzic_pkg::PH_UNPADDED;
                end
              endcase
            end
          end
          xzic_pkg::PH_PADDING: begin
            if (pad_q < 3'd4) begin
              pad_d = pad_q + 3'd1;
            end
          end
          default: begin
          end
        endcase
      end else begin
        tail_d[fill_q[1:0]] = in_byte_q;
        fill_d = fill_q + 3'd1;
      end

      if (total_q != TotalMax) begin
        total_d = total_q + xzic_pkg::TotalW'(1);
      end
    end
  end

  // Final status, from the state as it stands after the last byte.
  assign tail_word = {tail_d[3], tail_d[2], tail_d[1], tail_d[0]};

  always_comb begin
    if (total_d[1:0] != 2'b00 || total_d < xzic_pkg::TotalW'(8) || total_d == TotalMax) begin
      status = xzic_pkg::ST_SIZE;
    end else if (~crc_d != tail_word) begin
      status = xzic_pkg::ST_CRC;
    end else if (ferr_d != xzic_pkg::ST_OK) begin
      status = ferr_d;
    end else begin
      unique case (phase_d)
        xzic_pkg::PH_INDICATOR: status = xzic_pkg::ST_INDICATOR;
        xzic_pkg::PH_COUNT:     status = xzic_pkg::ST_COUNT;
        xzic_pkg::PH_UNPADDED:  status = xzic_pkg::ST_UNPADDED;
        xzic_pkg::PH_UNCOMP:    status = xzic_pkg::ST_UNCOMPRESSED;
        xzic_pkg::PH_PADDING:   status = (pad_d > 3'd3) ? xzic_pkg::ST_PADDING
                                                        : xzic_pkg::ST_OK;
        default:                status = xzic_pkg::ST_OK;
      endcase
    end
  end

  // State registers; a processed last byte returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        tail_q[i] <= 8'h00;
      end
      fill_q  <= 3'd0;
      total_q <= '0;
      crc_q   <= 32'hFFFF_FFFF;
      phase_q <= xzic_pkg::PH_INDICATOR;
      vval_q  <= '0;
      vpos_q  <= '0;
      rec_q   <= '0;
      bsum_q  <= '0;
      usum_q  <= '0;
      pad_q   <= 3'd0;
      ferr_q  <= xzic_pkg::ST_OK;
    end else if (advance && in_last_q) begin
      for (int i = 0; i < 4; i++) begin
        tail_q[i] <= 8'h00;
      end
      fill_q  <= 3'd0;
      total_q <= '0;
      crc_q   <= 32'hFFFF_FFFF;
      phase_q <= xzic_pkg::PH_INDICATOR;
      vval_q  <= '0;
      vpos_q  <= '0;
      rec_q   <= '0;
      bsum_q  <= '0;
      usum_q  <= '0;
      pad_q   <= 3'd0;
      ferr_q  <= xzic_pkg::ST_OK;
    end else begin
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      crc_q   <= crc_d;
      phase_q <= phase_d;
      vval_q  <= vval_d;
      vpos_q  <= vpos_d;
      rec_q   <= rec_d;
      bsum_q  <= bsum_d;
      usum_q  <= usum_d;
      pad_q   <= pad_d;
      ferr_q  <= ferr_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_block_q  <= (status == xzic_pkg::ST_OK) ? bsum_d : 64'd0;
      out_uncomp_q <= (status == xzic_pkg::ST_OK) ? usum_d : 64'd0;
      out_status_q <= status;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.block_bytes        = out_block_q;
  assign out_o.uncompressed_bytes = out_uncomp_q;
  assign out_o.status             = out_status_q;

endmodule

`default_nettype wire

FILE: rtl/xzic_checker.sv
// ----------------------------------------------------------------------------
// xzic_checker
// Port-level assertions for the xz index field checker, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xz_index_field_checker_defines.svh"

module xzic_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        res_valid_i,
  input wire logic        res_ready_i,
  input wire logic [63:0] block_bytes_i,
  input wire logic [63:0] uncompressed_bytes_i,
  input wire logic [2:0]  status_i
);

  // A failed check never reports partial sums.
  `XZIC_ASSERT_NOW(a_err_sums_zero,
    res_valid_i && status_i != xzic_pkg::ST_OK,
    block_bytes_i == 64'd0 && uncompressed_bytes_i == 64'd0,
    "sums not zero on a failed check")

  // Every block contributes a multiple of four, so a good total is aligned.
  `XZIC_ASSERT_NOW(a_block_aligned,
    res_valid_i && status_i == xzic_pkg::ST_OK,
    block_bytes_i[1:0] == 2'b00,
    "block byte total not a multiple of four")

  `XZIC_ASSERT_NEXT(a_res_holds,
    res_valid_i && !res_ready_i,
    res_valid_i,
    "result beat dropped while stalled")

  `XZIC_ASSERT_NEXT(a_res_stable,
    res_valid_i && !res_ready_i,
    $stable(status_i) && $stable(block_bytes_i) && $stable(uncompressed_bytes_i),
    "result beat changed while stalled")

endmodule

bind xz_index_field_checker xzic_checker u_xzic_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .res_valid_i          (out_o.valid),
  .res_ready_i          (out_o.ready),
  .block_bytes_i        (out_o.block_bytes),
  .uncompressed_bytes_i (out_o.uncompressed_bytes),
  .status_i             (out_o.status)
);

`default_nettype wire

FILE: tb/sv/xzic_checker.sv
// ----------------------------------------------------------------------------
// xzic_tb_checker
// Watches both channels of the xz index field checker, predicts the result
// of every index field from the accepted byte beats and compares each result
// beat against the oldest prediction.
// ----------------------------------------------------------------------------

module xzic_tb_checker #(
  parameter int unsigned MAX_VARINT_BYTES = xzic_pkg::MaxVarintBytes
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  xzic_byte_if              byte_i,
  xzic_res_if               res_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o,
  output int unsigned       results_o,
  output int unsigned       clean_o,
  output logic [7:0]        seen_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import xzic_pkg::*;

  typedef struct packed {
    logic [63:0] block_bytes;
    logic [63:0] uncompressed_bytes;
    status_e     status;
  } field_verdict_t;

  // Verdicts of finished fields whose result beat has not been seen yet.
  field_verdict_t field_verdicts[$];

  // Shadow of the field state.
  logic [7:0]  tail_q [4];
  logic [2:0]  tail_fill_q;
  logic [34:0] total_q;
  logic [31:0] crc_q;
  phase_e      phase_q;
  logic [62:0] acc_q;
  logic [3:0]  acc_pos_q;
  logic [62:0] records_q;
  logic [63:0] blk_sum_q;
  logic [63:0] unc_sum_q;
  logic [2:0]  pad_q;
  status_e     err_q;

  int unsigned mismatch_cnt = 0;
  int unsigned pending_cnt  = 0;
  int unsigned result_cnt   = 0;
  int unsigned clean_cnt    = 0;
  logic [7:0]  seen_q       = '0;

  assign mismatches_o = mismatch_cnt;
  assign pending_o    = pending_cnt;
  assign results_o    = result_cnt;
  assign clean_o      = clean_cnt;
  assign seen_o       = seen_q;

  function automatic void clear_field();
    foreach (tail_q[i]) tail_q[i] = '0;
    tail_fill_q = '0;
    total_q     = '0;
    crc_q       = '1;
    phase_q     = PH_INDICATOR;
    acc_q       = '0;
    acc_pos_q   = '0;
    records_q   = '0;
    blk_sum_q   = '0;
    unc_sum_q   = '0;
    pad_q       = '0;
    err_q       = ST_OK;
  endfunction

  // Reflected CRC-32, one bit per step.
  function automatic logic [31:0] crc_after(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = {1'b0, r[31:1]} ^ (r[0] ? CrcPoly : 32'd0);
    return r;
  endfunction

  function automatic void halt_parse(input status_e code);
    err_q   = code;
    phase_q = PH_HALT;
  endfunction

  function automatic void parse_body_byte(input logic [7:0] b);
    status_e     fld_err;
    logic [62:0] val;
    fld_err = (phase_q == PH_COUNT)    ? ST_COUNT :
              (phase_q == PH_UNPADDED) ? ST_UNPADDED : ST_UNCOMPRESSED;
    case (phase_q)
      PH_INDICATOR: begin
        if (b != 8'h00) halt_parse(ST_INDICATOR);
        else phase_q = PH_COUNT;
      end
      PH_COUNT, PH_UNPADDED, PH_UNCOMP: begin
        // A zero byte after the first one of a varint is never allowed.
        if (acc_pos_q >= MAX_VARINT_BYTES || acc_pos_q >= 4'd9 ||
            (acc_pos_q != 4'd0 && b == 8'h00)) begin
          halt_parse(fld_err);
        end else begin
          acc_q = acc_q | (63'(b[6:0]) << (7 * acc_pos_q));
          if (b[7]) begin
            if (acc_pos_q + 1 >= MAX_VARINT_BYTES) halt_parse(fld_err);
            else acc_pos_q = acc_pos_q + 4'd1;
          end else begin
            val       = acc_q;
            acc_q     = '0;
            acc_pos_q = '0;
            case (phase_q)
              PH_COUNT: begin
                records_q = val;
                phase_q   = (val == '0) ? PH_PADDING : PH_UNPADDED;
              end
              PH_UNPADDED: begin
                blk_sum_q = blk_sum_q + (((64'(val) - 64'd1) & ~64'h3) + 64'd4);
                phase_q   = PH_UNCOMP;
              end
              default: begin
                unc_sum_q = unc_sum_q + 64'(val);
                records_q = records_q - 63'd1;
                phase_q   = (records_q == '0) ? PH_PADDING : PH_UNPADDED;
              end
            endcase
          end
        end
      end
      PH_PADDING: begin
        if (pad_q < 3'd4) pad_q = pad_q + 3'd1;
      end
      default: ;
    endcase
  endfunction

  // One accepted byte beat. The newest four bytes wait in a window; a byte
  // reaches the CRC and the parser only when it is pushed out, so the
  // trailing CRC word is never parsed.
  function automatic void track_index_byte(input logic [7:0] b, input logic is_last);
    logic [7:0]     old;
    logic [31:0]    word;
    status_e        st;
    field_verdict_t v;
    if (tail_fill_q >= 3'd4) begin
      old       = tail_q[0];
      tail_q[0] = tail_q[1];
      tail_q[1] = tail_q[2];
      tail_q[2] = tail_q[3];
      tail_fill_q = 3'd3;
      crc_q = crc_after(crc_q, old);
      parse_body_byte(old);
    end
    tail_q[tail_fill_q[1:0]] = b;
    tail_fill_q = tail_fill_q + 3'd1;
    if (total_q != '1) total_q = total_q + 35'd1;
    if (!is_last) return;

    word = {tail_q[3], tail_q[2], tail_q[1], tail_q[0]};
    if (total_q[1:0] != 2'b00 || total_q < 35'd8 || total_q == '1) begin
      st = ST_SIZE;
    end else if (~crc_q != word) begin
      st = ST_CRC;
    end else if (err_q != ST_OK) begin
      st = err_q;
    end else begin
      // A field that ends before its records are complete fails on the
      // field that was being read.
      case (phase_q)
        PH_INDICATOR: st = ST_INDICATOR;
        PH_COUNT:     st = ST_COUNT;
        PH_UNPADDED:  st = ST_UNPADDED;
        PH_UNCOMP:    st = ST_UNCOMPRESSED;
        PH_PADDING:   st = (pad_q > 3'd3) ? ST_PADDING : ST_OK;
        default:      st = ST_OK;
      endcase
    end
    v.status             = st;
    v.block_bytes        = (st == ST_OK) ? blk_sum_q : 64'd0;
    v.uncompressed_bytes = (st == ST_OK) ? unc_sum_q : 64'd0;
    field_verdicts.push_back(v);
    seen_q[st] = 1'b1;
    if (st == ST_OK) clean_cnt++;
    clear_field();
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_cnt++;
    $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    field_verdict_t v;
    if (!rst_ni) begin
      clear_field();
      field_verdicts.delete();
      pending_cnt = 0;
    end else begin
      if (byte_i.valid && byte_i.ready) track_index_byte(byte_i.index_byte, byte_i.last);
      if (res_i.valid && res_i.ready) begin
        result_cnt++;
        if (field_verdicts.size() == 0) begin
          flag_mismatch("unexpected result", 64'(res_i.status), 64'd0);
        end else begin
          v = field_verdicts.pop_front();
          if (res_i.status !== v.status)
            flag_mismatch("status", 64'(res_i.status), 64'(v.status));
          if (res_i.block_bytes !== v.block_bytes)
            flag_mismatch("block_bytes", res_i.block_bytes, v.block_bytes);
          if (res_i.uncompressed_bytes !== v.uncompressed_bytes)
            flag_mismatch("uncompressed_bytes", res_i.uncompressed_bytes,
                          v.uncompressed_bytes);
        end
      end
      pending_cnt = field_verdicts.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the xz index field checker: sends index fields
// byte by byte, mostly well formed with random records, the rest broken or
// noise, while a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import xzic_pkg::*;

  // Stimulus stops once both of these are reached.
  localparam int unsigned ByteTarget  = 1000;
  localparam int unsigned FieldTarget = 40;
  // Cycles without any beat on either channel before the run is abandoned.
  // The slowest correct stretch is a long sender gap plus a long receiver
  // stall plus the pass through the input and result registers, well below this.
  localparam int unsigned IdleLimit   = 2000;
  // Cycles allowed after the last result for any stray beat to show up.
  localparam int unsigned DrainCycles = 8;

  // Ways in which a generated varint can be malformed.
  typedef enum int unsigned {
    VF_NONE,
    VF_ZERO_TAIL,
    VF_OVERLONG
  } varint_flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  xzic_byte_if byte_if ();
  xzic_res_if  res_if ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned results;
  int unsigned clean;
  logic [7:0]  seen;

  xz_index_field_checker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  xzic_tb_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_if),
    .res_i        (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .results_o    (results),
    .clean_o      (clean),
    .seen_o       (seen)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The bytes of the field about to be sent, in file order.
  logic [7:0]  field_q[$];
  int unsigned bytes_sent  = 0;
  int unsigned fields_sent = 0;
  // The sender either streams without pause or works in bursts; the choice
  // is made again for every field.
  bit          bursty      = 1'b0;
  int unsigned burst_left  = 0;

  // Receiver stalls follow a rotating 16-bit pattern that is replaced when
  // its random age runs out. An all-ones pattern gives stretches with no stall.
  logic [15:0] stall_pat  = '1;
  int unsigned stall_age  = 0;

  always @(negedge clk_i) begin
    if (stall_age == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = 16'($urandom);
        2:       stall_pat = 16'h0001 << $urandom_range(0, 15);
        default: stall_pat = 16'($urandom) | 16'($urandom);
      endcase
      stall_age = $urandom_range(16, 80);
    end
    stall_age--;
    res_if.ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  // Watchdog: a hung handshake on either side ends the run as a failure.
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                 IdleLimit, pending);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // A random record size. Zero and the largest 63-bit value are the
  // extremes; zero rounds up to zero in the block sum. Most sizes have a
  // random magnitude, so varints of every length from one to nine bytes come.
  function automatic logic [62:0] pick_size();
    logic [62:0] v;
    v = 63'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 63'($urandom_range(1, 8));
      default: return v >> $urandom_range(0, 62);
    endcase
  endfunction

  function automatic varint_flaw_e pick_flaw(input bit broken);
    if (!broken || $urandom_range(0, 5) != 0) return VF_NONE;
    return $urandom_range(0, 1) ? VF_ZERO_TAIL : VF_OVERLONG;
  endfunction

  function automatic void push_varint(input logic [62:0] v, input varint_flaw_e flaw);
    logic [62:0] r;
    r = v;
    if (flaw == VF_OVERLONG) begin
      // Continuation still set on the last byte the format allows.
      repeat (MaxVarintBytes) field_q.push_back(8'h80 | 8'($urandom));
      field_q.push_back(8'($urandom_range(1, 127)));
      return;
    end
    while (r > 63'd127) begin
      field_q.push_back({1'b1, r[6:0]});
      r = r >> 7;
    end
    if (flaw == VF_ZERO_TAIL) begin
      field_q.push_back({1'b1, r[6:0]});
      field_q.push_back(8'h00);
    end else begin
      field_q.push_back({1'b0, r[6:0]});
    end
  endfunction

  // Pads the body to a multiple of four with random bytes (their values are
  // not checked), then appends the CRC-32 of the body, little endian. A
  // broken field may get four extra padding bytes, a flipped CRC bit or a
  // length that is off by a few bytes.
  function automatic void seal_field(input bit broken);
    logic [31:0] crc;
    int unsigned npad;
    npad = (4 - field_q.size() % 4) % 4;
    if (broken && $urandom_range(0, 5) == 0) npad += 4;
    repeat (npad) field_q.push_back(8'($urandom));
    crc = '1;
    foreach (field_q[i]) crc = crc32_byte(crc, field_q[i]);
    crc = ~crc;
    if (broken && $urandom_range(0, 7) == 0) crc = crc ^ (32'd1 << $urandom_range(0, 31));
    field_q.push_back(crc[7:0]);
    field_q.push_back(crc[15:8]);
    field_q.push_back(crc[23:16]);
    field_q.push_back(crc[31:24]);
    if (broken && $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 1)) void'(field_q.pop_back());
      else repeat ($urandom_range(1, 3)) field_q.push_back(8'($urandom));
    end
  endfunction

  // An index field with nrec records of random sizes. A broken field may
  // carry a bad indicator, a record count that disagrees with the records,
  // malformed varints or a body cut short in the middle of a varint.
  function automatic void build_field(input int unsigned nrec, input bit broken);
    int unsigned count;
    field_q.delete();
    field_q.push_back((broken && $urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                            : 8'h00);
    count = nrec;
    if (broken && $urandom_range(0, 7) == 0) count = nrec + $urandom_range(1, 2);
    else if (broken && nrec > 0 && $urandom_range(0, 7) == 0) count = nrec - 1;
    push_varint(63'(count), pick_flaw(broken));
    repeat (nrec) begin
      push_varint(pick_size(), pick_flaw(broken));
      push_varint(pick_size(), pick_flaw(broken));
    end
    if (broken && field_q.size() > 2 && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 2)) void'(field_q.pop_back());
    seal_field(broken);
  endfunction

  // One byte beat. Inputs change only at the falling edge; the beat is taken
  // at the first rising edge that sees ready high.
  task automatic put_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        byte_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    byte_if.valid      <= 1'b1;
    byte_if.index_byte <= b;
    byte_if.last       <= is_last;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_field();
    bursty     = ($urandom_range(0, 3) != 0);
    burst_left = $urandom_range(0, 6);
    foreach (field_q[i]) put_byte(field_q[i], i == field_q.size() - 1);
    fields_sent++;
  endtask

  initial begin
    rst_ni             = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.index_byte = 8'h00;
    byte_if.last       = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed fields. The smallest valid index: indicator, a zero record
    // count, two padding bytes and the CRC, eight bytes in all.
    build_field(0, 1'b0);
    send_field();
    // A field of a single byte, all ones, is far too short.
    field_q = '{8'hFF};
    send_field();
    // Four zero bytes: a multiple of four but still below the minimum size.
    field_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_field();
    // A nonzero indicator under a correct CRC.
    field_q = '{8'hFF, 8'h00};
    seal_field(1'b0);
    send_field();

    // Random fields: mostly well formed with random records, a share with
    // injected faults, and some pure noise.
    while (bytes_sent < ByteTarget || fields_sent < FieldTarget) begin
      case ($urandom_range(0, 9))
        0: begin
          field_q.delete();
          repeat ($urandom_range(1, 40)) field_q.push_back(8'($urandom));
        end
        1, 2: build_field($urandom_range(0, 4), 1'b1);
        default: build_field(($urandom_range(0, 7) == 0) ? $urandom_range(4, 10)
                                                         : $urandom_range(0, 3), 1'b0);
      endcase
      send_field();
    end
    byte_if.valid <= 1'b0;

    // The watchdog bounds this wait.
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d index bytes in %0d fields and checked %0d results, %0d clean.",
             bytes_sent, fields_sent, results, clean);
    $display("Status codes reached, one bit per code with code 7 leftmost: %b.", seen);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
